@@ rtl/core/fbp_pkg.sv @@
// Shared constants, coefficient table and control types of the band-pass FIR filter.
`default_nettype none

package fbp_pkg;

  // Default filter geometry.
  localparam int TAPS         = 141;
  localparam int SAMPLE_WIDTH = 16;
  localparam int COEF_WIDTH   = 18;

  // Q1.17 coefficient table: each entry is the design coefficient times 2^17, rounded.
  localparam int COEF_COUNT = 141;
  localparam int COEF_TABLE [COEF_COUNT] = '{
      1354,   1602,   1148,    -25,   -887,   -681,    182,    549,
      -106,  -1009,  -1028,   -127,    507,    -47,  -1195,  -1494,
      -500,    551,    257,  -1097,  -1772,   -779,    746,    885,
      -564,  -1693,   -867,   1084,   1787,    374,  -1268,   -820,
      1412,   2731,   1479,   -702,   -855,   1441,   3358,   2382,
      -326,  -1268,    864,   3319,   2723,   -452,  -2301,   -511,
      2445,   2339,  -1228,  -4037,  -2647,    889,   1414,  -2535,
     -6394,  -5299,   -786,    637,  -4002,  -9442,  -8338,  -1401,
      1892,  -5156, -15808, -14486,   6076,  33886,  46836,  33886,
      6076, -14486, -15808,  -5156,   1892,  -1401,  -8338,  -9442,
     -4002,    637,   -786,  -5299,  -6394,  -2535,   1414,    889,
     -2647,  -4037,  -1228,   2339,   2445,   -511,  -2301,   -452,
      2723,   3319,    864,  -1268,   -326,   2382,   3358,   1441,
      -855,   -702,   1479,   2731,   1412,   -820,  -1268,    374,
      1787,   1084,   -867,  -1693,   -564,    885,    746,   -779,
     -1772,  -1097,    257,    551,   -500,  -1494,  -1195,    -47,
       507,   -127,  -1028,  -1009,   -106,    549,    182,   -681,
      -887,    -25,   1148,   1602,   1354
  };

  // Coefficient lookup; taps beyond the table weigh zero.
  function automatic int coef_at(input int idx);
    if (idx >= 0 && idx < COEF_COUNT) begin
      return COEF_TABLE[idx];
    end
    return 0;
  endfunction

  // Commands from the sequencer to the serial multiply-accumulate unit.
  typedef struct packed {
    logic clear;  // zero the accumulator for a new item
    logic start;  // load a sample and a coefficient and begin a product
  } fbp_mac_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/fbp_delay_mem.sv @@
// Circular delay line memory with per-entry valid bits and a registered read port.
`default_nettype none

module fbp_delay_mem #(
  parameter int TAPS         = fbp_pkg::TAPS,
  parameter int SAMPLE_WIDTH = fbp_pkg::SAMPLE_WIDTH,
  localparam int AW          = (TAPS > 1) ? $clog2(TAPS) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    wr_en,
  input  wire logic [AW-1:0]           wr_addr,
  input  wire logic [SAMPLE_WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]           rd_addr,
  output      logic [SAMPLE_WIDTH-1:0] rd_data
);

  logic [SAMPLE_WIDTH-1:0] mem [TAPS];
  logic [TAPS-1:0]         written;

  // Entries never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= written[rd_addr] ? mem[rd_addr] : '0;
  end

endmodule

`default_nettype wire

@@ rtl/core/fbp_serial_mac.sv @@
// Bit-serial signed multiplier feeding a full-width accumulator.
`default_nettype none

module fbp_serial_mac #(
  parameter int SAMPLE_WIDTH = fbp_pkg::SAMPLE_WIDTH,
  parameter int COEF_WIDTH   = fbp_pkg::COEF_WIDTH,
  parameter int ACC_WIDTH    = fbp_pkg::SAMPLE_WIDTH + fbp_pkg::COEF_WIDTH + 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire fbp_pkg::fbp_mac_ctrl_t       ctrl,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
  input  wire logic signed [COEF_WIDTH-1:0]   coef,
  output      logic                         done,
  output      logic signed [ACC_WIDTH-1:0]  acc
);

  import fbp_pkg::*;

  localparam int PW    = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int CNT_W = $clog2(SAMPLE_WIDTH);

  logic                    busy;
  logic [CNT_W-1:0]        cnt;
  logic [SAMPLE_WIDTH-1:0] sreg;
  logic signed [COEF_WIDTH-1:0] coef_r;
  logic signed [PW-1:0]    prod;
  logic                    last;
  logic signed [COEF_WIDTH:0] hi;
  logic signed [COEF_WIDTH:0] addend;
  logic signed [COEF_WIDTH:0] sum;
  logic signed [PW-1:0]    prod_next;

  // One sample bit per cycle, LSB first; the sign bit carries negative weight.
  assign last = (cnt == CNT_W'(SAMPLE_WIDTH - 1));
  assign hi   = {prod[PW-1], prod[PW-1 -: COEF_WIDTH]};

  always_comb begin
    if (!sreg[0]) begin
      addend = '0;
    end else if (last) begin
      addend = -{coef_r[COEF_WIDTH-1], coef_r};
    end else begin
      addend = {coef_r[COEF_WIDTH-1], coef_r};
    end
  end

  assign sum       = hi + addend;
  assign prod_next = {sum, prod[SAMPLE_WIDTH-1:1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && last;
      if (ctrl.start) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      cnt    <= '0;
      sreg   <= sample;
      coef_r <= coef;
      prod   <= '0;
    end else if (busy) begin
      cnt  <= cnt + 1'b1;
      sreg <= sreg >> 1;
      prod <= prod_next;
    end
  end

  // The finished product is added the cycle after its last bit step.
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (done) begin
      acc <= acc + ACC_WIDTH'(prod);
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/fir_bandpass_141_tap_core.sv @@
// Top level of the symmetric band-pass FIR filter: sequencer, rounding and output register.
`default_nettype none

// Symmetric band-pass FIR filter, one filtered Q1.15 item for each Q1.15 sample item.
// Each accepted sample is written into a circular delay line at the current write
// position, then every tap is multiplied by its Q1.17 coefficient from a constant table
// and summed in a full-width accumulator; the sum is rounded half up to Q1.15 and
// saturated. The multiplier is bit serial: it consumes one sample bit per cycle, and each
// tap takes SAMPLE_WIDTH bit steps followed by one accumulate step. After an item is
// accepted, sample_ready stays low until the item has run through every tap and its
// result has been rounded and moved to the output register, so the next item is not
// taken before the last one is through. This interval is set by the single shared
// serial multiplier walking the taps in turn; a receiver that holds off the previous
// result lengthens it further. The delay line is a memory with one valid bit per
// entry, so entries not yet written since reset read as zero and no clearing pass is
// needed after reset.
// A finished result waits in the output register; the next sample is accepted while it
// waits. A new result is not posted until the previous one has been taken, and
// sample_ready stays low while it is held back.

module fir_bandpass_141_tap_core #(
  parameter int TAPS         = fbp_pkg::TAPS,
  parameter int SAMPLE_WIDTH = fbp_pkg::SAMPLE_WIDTH,
  parameter int COEF_WIDTH   = fbp_pkg::COEF_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           sample_valid,
  output      logic                           sample_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
  output      logic                           filtered_valid,
  input  wire logic                           filtered_ready,
  output      logic signed [SAMPLE_WIDTH-1:0] filtered
);

  import fbp_pkg::*;

  localparam int AW        = (TAPS > 1) ? $clog2(TAPS) : 1;
  // Room for TAPS full-width products without overflow.
  localparam int ACC_WIDTH = SAMPLE_WIDTH + COEF_WIDTH + AW;

  localparam logic signed [ACC_WIDTH-1:0] ROUND_BIAS = ACC_WIDTH'(1) << (COEF_WIDTH - 2);
  localparam logic signed [ACC_WIDTH-1:0] SAT_MAX    =
    (ACC_WIDTH'(1) << (SAMPLE_WIDTH - 1)) - ACC_WIDTH'(1);
  localparam logic signed [ACC_WIDTH-1:0] SAT_MIN    = -SAT_MAX - ACC_WIDTH'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_LOAD,
    S_MAC,
    S_ROUND
  } state_t;

  state_t                         state;
  logic [AW-1:0]                  pos;
  logic [AW-1:0]                  rd_addr;
  logic [AW-1:0]                  tap;
  logic                           accept;
  logic                           last_tap;
  logic [AW-1:0]                  rd_addr_dec;
  logic [AW-1:0]                  pos_inc;
  logic [SAMPLE_WIDTH-1:0]        rd_data;
  logic signed [COEF_WIDTH-1:0]   mac_coef;
  fbp_mac_ctrl_t                  mac_ctrl;
  logic                           mac_done;
  logic signed [ACC_WIDTH-1:0]    acc;
  logic signed [ACC_WIDTH-1:0]    rounded;
  logic signed [SAMPLE_WIDTH-1:0] saturated;

  assign sample_ready = (state == S_IDLE);
  assign accept       = sample_valid && sample_ready;
  assign last_tap     = (tap == AW'(TAPS - 1));

  // Taps walk backward through the circular buffer from the newest sample.
  assign rd_addr_dec  = (rd_addr == '0) ? AW'(TAPS - 1) : rd_addr - 1'b1;
  assign pos_inc      = (pos == AW'(TAPS - 1)) ? '0 : pos + 1'b1;

  // A product started from S_MAC belongs to the tap after the one just finished.
  assign mac_coef       = COEF_WIDTH'(coef_at(int'(tap) + int'(state == S_MAC)));
  assign mac_ctrl.clear = accept;
  assign mac_ctrl.start = (state == S_LOAD) || (state == S_MAC && mac_done && !last_tap);

  fbp_delay_mem #(
    .TAPS         (TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_delay_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_addr (pos),
    .wr_data (sample),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  fbp_serial_mac #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH),
    .ACC_WIDTH    (ACC_WIDTH)
  ) u_serial_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .sample (rd_data),
    .coef   (mac_coef),
    .done   (mac_done),
    .acc    (acc)
  );

  // Round half up by adding half an output LSB, drop the coefficient fraction, then clamp.
  always_comb begin
    rounded = (acc + ROUND_BIAS) >>> (COEF_WIDTH - 1);
    if (rounded > SAT_MAX) begin
      saturated = SAT_MAX[SAMPLE_WIDTH-1:0];
    end else if (rounded < SAT_MIN) begin
      saturated = SAT_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      saturated = rounded[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      pos            <= '0;
      rd_addr        <= '0;
      tap            <= '0;
      filtered_valid <= 1'b0;
    end else begin
      // A new result may replace one that is being taken in the same cycle.
      if (state == S_ROUND && (!filtered_valid || filtered_ready)) begin
        filtered_valid <= 1'b1;
      end else if (filtered_valid && filtered_ready) begin
        filtered_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            rd_addr <= pos;
            tap     <= '0;
            state   <= S_FETCH;
          end
        end
        S_FETCH: begin
          // The newest sample is being read out of the delay line.
          state <= S_LOAD;
        end
        S_LOAD: begin
          // First product starts; prefetch the next older sample meanwhile.
          rd_addr <= rd_addr_dec;
          state   <= S_MAC;
        end
        S_MAC: begin
          if (mac_done) begin
            if (last_tap) begin
              pos   <= pos_inc;
              state <= S_ROUND;
            end else begin
              tap     <= tap + 1'b1;
              rd_addr <= rd_addr_dec;
            end
          end
        end
        S_ROUND: begin
          if (!filtered_valid || filtered_ready) begin
            filtered <= saturated;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
